>>> design/mews_pkg.sv
// Package for the motion energy window sum block.
// Holds shared widths, pipeline control types and the per-axis filter function.
// Used by every module in the design folder; depends on nothing.
package mews_pkg;

    localparam int SampleW = 16;
    localparam int DcW = 20;
    localparam int SquareW = 32;
    localparam int EnergyW = 32;
    localparam int CfgW = 7;
    localparam int AxisCount = 3;
    localparam int DefRingDepth = 64;

    typedef logic signed [SampleW-1:0] t_sample;
    typedef logic signed [DcW-1:0] t_dc;

    typedef struct packed {
        logic clear;
        logic advance;
    } t_ctl;

    typedef struct packed {
        logic signed [DcW-1:0] dc;
        logic [SquareW-1:0] sq;
    } t_axis_res;

    // One tracker update followed by the squared high-pass residue.
    function automatic t_axis_res axis_step(input t_sample s, input t_dc dc, input logic seeded);
        logic signed [DcW-1:0] s_q4;
        logic signed [DcW-1:0] base;
        logic signed [DcW:0] diff;
        logic signed [DcW:0] sum;
        logic signed [SampleW:0] h;
        logic signed [2*SampleW+1:0] prod;
        t_axis_res r;
        s_q4 = {s, 4'b0000};
        base = seeded ? dc : s_q4;
        diff = (DcW+1)'(s_q4) - (DcW+1)'(base);
        sum = (DcW+1)'(base) + (diff >>> 4);
        r.dc = sum[DcW-1:0];
        h = (SampleW+1)'(s) - (SampleW+1)'(r.dc >>> 4);
        prod = (2*SampleW+2)'(h) * (2*SampleW+2)'(h);
        r.sq = prod[SquareW-1:0];
        return r;
    endfunction

endpackage

>>> design/mews_axis_filter.sv
// Per-axis DC trackers, high-pass residues and saturated sum of squares.
// Result lands in the energy register; uses mews_pkg.
module mews_axis_filter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mews_pkg::t_ctl                 i_ctl,
    input  mews_pkg::t_sample              i_accel [mews_pkg::AxisCount],
    output logic [mews_pkg::EnergyW-1:0]   o_energy
);

    mews_pkg::t_dc r_dc [mews_pkg::AxisCount];
    logic r_seeded;
    logic [mews_pkg::EnergyW-1:0] r_energy;

    mews_pkg::t_axis_res axis_res [mews_pkg::AxisCount];
    logic [mews_pkg::SquareW+1:0] e_sum;
    logic [mews_pkg::EnergyW-1:0] n_energy;

    always_comb begin
        for (int i = 0; i < mews_pkg::AxisCount; i++) begin
            axis_res[i] = mews_pkg::axis_step(i_accel[i], r_dc[i], r_seeded);
        end
        e_sum = (mews_pkg::SquareW+2)'(axis_res[0].sq) + (mews_pkg::SquareW+2)'(axis_res[1].sq)
              + (mews_pkg::SquareW+2)'(axis_res[2].sq);
        n_energy = (|e_sum[mews_pkg::SquareW+1:mews_pkg::EnergyW]) ? '1
                 : e_sum[mews_pkg::EnergyW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_seeded <= 1'b0;
            for (int i = 0; i < mews_pkg::AxisCount; i++) begin
                r_dc[i] <= '0;
            end
        end else if (i_ctl.advance) begin
            r_seeded <= 1'b1;
            for (int i = 0; i < mews_pkg::AxisCount; i++) begin
                r_dc[i] <= axis_res[i].dc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_energy <= n_energy;
        end
    end

    assign o_energy = r_energy;

endmodule

>>> design/mews_window.sv
// Energy ring, fill count, write slot and running total with saturated result.
// The ring read is prefetched for the next slot; uses mews_pkg.
module mews_window #(
    parameter int RING_DEPTH = mews_pkg::DefRingDepth,
    parameter int LEN_W = $clog2(RING_DEPTH + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mews_pkg::t_ctl                 i_ctl,
    input  logic [LEN_W-1:0]               i_len,
    input  logic [mews_pkg::EnergyW-1:0]   i_energy,
    output logic [mews_pkg::EnergyW-1:0]   o_sum
);

    localparam int SlotW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int TotW = mews_pkg::EnergyW + LEN_W;

    logic [mews_pkg::EnergyW-1:0] r_ring [RING_DEPTH];
    logic [mews_pkg::EnergyW-1:0] r_old;
    logic [SlotW-1:0] r_slot;
    logic [LEN_W-1:0] r_fill;
    logic [TotW-1:0] r_total;
    logic [mews_pkg::EnergyW-1:0] r_sum;

    logic full;
    logic [LEN_W-1:0] slot_cnt;
    logic [SlotW-1:0] n_slot;
    logic [LEN_W-1:0] n_fill;
    logic [TotW-1:0] n_total;
    logic [SlotW-1:0] rd_addr;

    always_comb begin
        full = (r_fill >= i_len);
        slot_cnt = LEN_W'(r_slot) + LEN_W'(1);
        n_slot = (slot_cnt >= i_len) ? '0 : SlotW'(slot_cnt);
        n_fill = full ? r_fill : r_fill + LEN_W'(1);
        n_total = r_total - (full ? TotW'(r_old) : '0) + TotW'(i_energy);
        rd_addr = i_ctl.advance ? n_slot : r_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_slot <= '0;
            r_fill <= '0;
            r_total <= '0;
        end else if (i_ctl.advance) begin
            r_slot <= n_slot;
            r_fill <= n_fill;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_ring[r_slot] <= i_energy;
            r_sum <= (|n_total[TotW-1:mews_pkg::EnergyW]) ? '1
                   : n_total[mews_pkg::EnergyW-1:0];
        end
        if (i_ctl.advance && rd_addr == r_slot) begin
            r_old <= i_energy;
        end else begin
            r_old <= r_ring[rd_addr];
        end
    end

    assign o_sum = r_sum;

endmodule

>>> design/motion_energy_window_sum.sv
// Top level of the motion energy window sum block.
// Holds the input register, window length register and pipeline handshake;
// instantiates mews_axis_filter and mews_window and uses mews_pkg.
//
// Channel   Dir  Payload (low bit first)              Request taken when
// s_axis    in   accel_x, accel_y, accel_z (48 bits)   s_axis_tvalid && s_axis_tready
// m_axis    out  window_energy (32 bits)               m_axis_tvalid && m_axis_tready
// cfg       in   window_length (7 bits)                i_cfg_valid && o_cfg_ready
//
// Three register stages: input register, energy register, result register.
// A request passes the energy and result registers; one per cycle unless stalled.
// The DC tracker loop and the running total loop each close through one register.
// Reset or a window length write clears trackers, fill count, slot and total.
// A stalled result holds every stage that is full; empty stages keep filling.
module motion_energy_window_sum #(
    parameter int RING_DEPTH = mews_pkg::DefRingDepth
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [3*mews_pkg::SampleW-1:0]    s_axis_tdata,  // accel_x, accel_y, accel_z
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mews_pkg::EnergyW-1:0]      m_axis_tdata,  // window_energy
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mews_pkg::CfgW-1:0]         i_cfg_data
);

    localparam int LenW = $clog2(RING_DEPTH + 1);

    mews_pkg::t_sample r_accel [mews_pkg::AxisCount];
    logic r_in_valid;
    logic r_e_valid;
    logic r_out_valid;
    logic [LenW-1:0] r_len;

    logic [LenW-1:0] n_len;
    logic cfg_write;
    logic out_adv;
    logic e_adv;
    logic in_take;
    mews_pkg::t_ctl filt_ctl;
    mews_pkg::t_ctl win_ctl;
    logic [mews_pkg::EnergyW-1:0] energy;

    assign o_cfg_ready = 1'b1;
    assign cfg_write = i_cfg_valid && o_cfg_ready;

    always_comb begin
        out_adv = r_e_valid && (!r_out_valid || m_axis_tready);
        e_adv = r_in_valid && (!r_e_valid || out_adv);
        s_axis_tready = !r_in_valid || e_adv;
        in_take = s_axis_tvalid && s_axis_tready;
        filt_ctl = '{clear: cfg_write, advance: e_adv};
        win_ctl = '{clear: cfg_write, advance: out_adv};
        if (i_cfg_data == '0) begin
            n_len = LenW'(1);
        end else if (int'(i_cfg_data) > RING_DEPTH) begin
            n_len = LenW'(RING_DEPTH);
        end else begin
            n_len = LenW'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_len <= LenW'(1);
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (e_adv) begin
                r_in_valid <= 1'b0;
            end
            if (e_adv) begin
                r_e_valid <= 1'b1;
            end else if (out_adv) begin
                r_e_valid <= 1'b0;
            end
            if (out_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_write) begin
                r_len <= n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            for (int i = 0; i < mews_pkg::AxisCount; i++) begin
                r_accel[i] <= s_axis_tdata[i*mews_pkg::SampleW +: mews_pkg::SampleW];
            end
        end
    end

    mews_axis_filter u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (filt_ctl),
        .i_accel  (r_accel),
        .o_energy (energy)
    );

    mews_window #(
        .RING_DEPTH (RING_DEPTH),
        .LEN_W      (LenW)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (win_ctl),
        .i_len    (r_len),
        .i_energy (energy),
        .o_sum    (m_axis_tdata)
    );

    assign m_axis_tvalid = r_out_valid;

    a_ready_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid)
        else $error("input stalled with an empty input register");

    a_result_from_energy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_e_valid))
        else $error("result appeared without an energy stage entry");

    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_write |=> (r_len != '0) && (int'(r_len) <= RING_DEPTH))
        else $error("window length out of range after a write");

endmodule

>>> tb/tb_motion_energy_window_sum.sv
// Self-checking testbench for motion_energy_window_sum: a queued stream driver, a stalling
// result monitor and a bit-exact model of the trackers, energy ring and running total.
// Depends on mews_pkg and the design top level only.
`timescale 1ns / 1ps

module tb_motion_energy_window_sum;

    localparam int RingDepth = mews_pkg::DefRingDepth;
    localparam int SettleCycles = 8;
    localparam int ReadyAlways = 0;
    localparam int ReadyRandom = 1;
    localparam int ReadySparse = 2;

    typedef struct packed {
        mews_pkg::t_sample z;
        mews_pkg::t_sample y;
        mews_pkg::t_sample x;
    } t_accel;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [3*mews_pkg::SampleW-1:0] s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [mews_pkg::EnergyW-1:0] m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [mews_pkg::CfgW-1:0] cfg_data = '0;

    t_accel sample_queue[$];
    logic [31:0] energy_expected[$];
    t_accel drv_item;
    int burst_left = 1;
    int gap_left = 0;
    int stall_mode = ReadyAlways;
    int stall_left = 0;
    int stall_tick = 0;
    int errors = 0;

    // Model state: trackers in Q4, energy ring and running total.
    bit trk_seeded;
    int trk_dc[3];
    bit [31:0] energy_ring[RingDepth];
    longint unsigned run_total;
    int fill_cnt;
    int wr_slot;
    int win_len;

    motion_energy_window_sum u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_valid),
        .s_axis_tready(s_ready),
        .s_axis_tdata (s_data),
        .m_axis_tvalid(m_valid),
        .m_axis_tready(m_ready),
        .m_axis_tdata (m_data),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic void clear_energy_state();
        trk_seeded = 1'b0;
        for (int k = 0; k < 3; k++) trk_dc[k] = 0;
        for (int k = 0; k < RingDepth; k++) energy_ring[k] = '0;
        run_total = 0;
        fill_cnt = 0;
        wr_slot = 0;
    endfunction

    function automatic void apply_window(input logic [mews_pkg::CfgW-1:0] v);
        int w;
        w = int'(v);
        if (w < 1) w = 1;
        if (w > RingDepth) w = RingDepth;
        clear_energy_state();
        win_len = w;
    endfunction

    function automatic logic [31:0] predict_energy(input t_accel a);
        int s[3];
        int h;
        longint sq;
        longint unsigned e;
        logic [31:0] e32;
        s[0] = a.x;
        s[1] = a.y;
        s[2] = a.z;
        e = 0;
        if (!trk_seeded) begin
            for (int k = 0; k < 3; k++) trk_dc[k] = s[k] * 16;
            trk_seeded = 1'b1;
        end
        for (int k = 0; k < 3; k++) begin
            trk_dc[k] = trk_dc[k] + ((s[k] * 16 - trk_dc[k]) >>> 4);
            h = s[k] - (trk_dc[k] >>> 4);
            sq = longint'(h) * longint'(h);
            e += longint'(sq);
        end
        e32 = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
        if (wr_slot >= win_len) wr_slot = 0;
        if (fill_cnt >= win_len) begin
            run_total -= energy_ring[wr_slot];
        end else begin
            fill_cnt++;
        end
        energy_ring[wr_slot] = e32;
        run_total += e32;
        wr_slot++;
        if (wr_slot >= win_len) wr_slot = 0;
        return (run_total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : run_total[31:0];
    endfunction

    function automatic mews_pkg::t_sample clamp_sample(input int v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return mews_pkg::t_sample'(v);
    endfunction

    function automatic mews_pkg::t_sample extreme_sample();
        case ($urandom_range(0, 3))
            0: return mews_pkg::t_sample'(-32768);
            1: return mews_pkg::t_sample'(32767);
            2: return mews_pkg::t_sample'(0);
            default: return mews_pkg::t_sample'(-1);
        endcase
    endfunction

    task automatic push_sample(input int x, input int y, input int z);
        t_accel a;
        a.x = clamp_sample(x);
        a.y = clamp_sample(y);
        a.z = clamp_sample(z);
        sample_queue.push_back(a);
    endtask

    // Mostly slow motion around a drifting level, with full-range noise and rail hits.
    task automatic queue_random(input int n);
        mews_pkg::t_sample smp[3];
        int lvl[3];
        int pick;
        t_accel a;
        for (int k = 0; k < 3; k++) lvl[k] = int'($urandom_range(0, 65535)) - 32768;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) lvl[$urandom_range(0, 2)] = int'($urandom_range(0, 65535)) - 32768;
            for (int k = 0; k < 3; k++) begin
                if (pick < 55) begin
                    smp[k] = clamp_sample(lvl[k] + int'($urandom_range(0, 128)) - 64);
                end else if (pick < 85) begin
                    smp[k] = mews_pkg::t_sample'($urandom_range(0, 65535));
                end else begin
                    smp[k] = extreme_sample();
                end
            end
            a.x = smp[0];
            a.y = smp[1];
            a.z = smp[2];
            sample_queue.push_back(a);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (sample_queue.size() != 0 || s_valid || energy_expected.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_window(input logic [mews_pkg::CfgW-1:0] v);
        wait_drained();
        repeat (SettleCycles) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_window(v);
    endtask

    // Stream driver: bursts of requests from the queue with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                energy_expected.push_back(predict_energy(drv_item));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (sample_queue.size() != 0) begin
                    drv_item = sample_queue.pop_front();
                    s_data <= drv_item;
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with its own back-pressure pattern.
    always @(posedge i_clk) begin
        if (m_valid && m_ready) begin
            if (energy_expected.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: actual %h", m_data);
            end else if (m_data !== energy_expected[0]) begin
                errors++;
                if (errors <= 10) begin
                    $display("window_energy mismatch: expected %h actual %h",
                             energy_expected[0], m_data);
                end
                void'(energy_expected.pop_front());
            end else begin
                void'(energy_expected.pop_front());
            end
        end
        if (stall_left <= 0) begin
            stall_mode = $urandom_range(ReadyAlways, ReadySparse);
            stall_left = $urandom_range(16, 160);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            ReadyAlways: m_ready <= 1'b1;
            ReadyRandom: m_ready <= ($urandom_range(0, 9) < 6);
            default: m_ready <= (stall_tick % 5 == 0);
        endcase
    end

    initial begin
        logic [mews_pkg::CfgW-1:0] plan[$];
        clear_energy_state();
        win_len = 1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Seeding, rails, sign flips and residues around the shift boundary.
        push_sample(0, 0, 0);
        push_sample(0, 0, 0);
        push_sample(32767, 32767, 32767);
        push_sample(-32768, -32768, -32768);
        push_sample(32767, 32767, 32767);
        push_sample(-32768, -32768, -32768);
        push_sample(32767, -32768, 0);
        push_sample(-32768, 32767, -1);
        push_sample(-1, -1, -1);
        push_sample(1, 1, 1);
        push_sample(-1, 1, -1);
        push_sample(16, -16, 15);
        push_sample(-17, 17, -15);
        push_sample(0, 0, 0);
        queue_random(100);

        plan = '{7'd0, 7'd127, 7'd64, 7'd2, 7'd65, 7'd7, 7'd33, 7'd1, 7'd3, 7'd16};
        plan.push_back(mews_pkg::CfgW'($urandom_range(0, 127)));
        plan.push_back(mews_pkg::CfgW'($urandom_range(0, 127)));
        foreach (plan[p]) begin
            write_window(plan[p]);
            @(negedge i_clk);
            // Rail-to-rail swings drive the running total into saturation on long windows.
            for (int i = 0; i < 6; i++) begin
                if (i % 2 == 0) push_sample(-32768, 32767, -32768);
                else push_sample(32767, -32768, 32767);
            end
            queue_random(100);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && energy_expected.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> files.f
design/mews_pkg.sv
design/mews_axis_filter.sv
design/mews_window.sv
design/motion_energy_window_sum.sv
tb/tb_motion_energy_window_sum.sv
